[hw/rtl/kdsl_pkg.sv]
// ----------------------------------------------------------------------------
// kdsl_pkg
// Shared types and constants for the five-key debounce with short/long press.
// ----------------------------------------------------------------------------
package kdsl_pkg;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned CFG_BITS    = 16;
  localparam int unsigned NUM_LADDER  = 4;

  // Configuration register indexes
  localparam logic [2:0] REG_STBY_LONG    = 3'd0;
  localparam logic [2:0] REG_STBY_DEB     = 3'd1;
  localparam logic [2:0] REG_LADDER_DEB   = 3'd2;
  localparam logic [2:0] REG_LADDER_LONG  = 3'd3;
  localparam logic [2:0] REG_RELEASE      = 3'd4;

  // Reset values of the configuration registers
  localparam logic [COUNT_BITS-1:0]  RST_STBY_LONG   = COUNT_BITS'(0);
  localparam logic [COUNT_BITS-1:0]  RST_STBY_DEB    = COUNT_BITS'(500);
  localparam logic [COUNT_BITS-1:0]  RST_LADDER_DEB  = COUNT_BITS'(50);
  localparam logic [COUNT_BITS-1:0]  RST_LADDER_LONG = COUNT_BITS'(8000);
  localparam logic [SAMPLE_BITS-1:0] RST_RELEASE     = SAMPLE_BITS'(842);

  // Ladder windows, bounds exclusive
  localparam logic [SAMPLE_BITS-1:0] UP_LO   = SAMPLE_BITS'(477);
  localparam logic [SAMPLE_BITS-1:0] UP_HI   = SAMPLE_BITS'(537);
  localparam logic [SAMPLE_BITS-1:0] DOWN_LO = SAMPLE_BITS'(644);
  localparam logic [SAMPLE_BITS-1:0] DOWN_HI = SAMPLE_BITS'(704);
  localparam logic [SAMPLE_BITS-1:0] CALL_LO = SAMPLE_BITS'(313);
  localparam logic [SAMPLE_BITS-1:0] CALL_HI = SAMPLE_BITS'(373);
  localparam logic [SAMPLE_BITS-1:0] PAIR_HI = SAMPLE_BITS'(30);

  // Ladder key slots
  localparam int unsigned LAD_UP   = 0;
  localparam int unsigned LAD_DOWN = 1;
  localparam int unsigned LAD_CALL = 2;
  localparam int unsigned LAD_PAIR = 3;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } key_ev_e;

  typedef struct packed {
    logic active;
    logic released;
  } key_ctrl_t;

  typedef struct packed {
    logic                   stby_level;
    logic [SAMPLE_BITS-1:0] ladder_sample;
  } key_in_t;

  typedef struct packed {
    logic [1:0] stby_event;
    logic [1:0] up_event;
    logic [1:0] down_event;
    logic [1:0] call_event;
    logic [1:0] pair_event;
  } key_out_t;

endpackage

[hw/rtl/kdsl_window.sv]
// ----------------------------------------------------------------------------
// kdsl_window
// Classifies one ladder sample into per-key active and released flags.
// ----------------------------------------------------------------------------
module kdsl_window import kdsl_pkg::*; (
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic [SAMPLE_BITS-1:0]      release_level_i,
  output key_ctrl_t [NUM_LADDER-1:0]  ctrl_o
);

  logic rel;

  assign rel = sample_i > release_level_i;

  always_comb begin
    ctrl_o[LAD_UP].active   = (sample_i > UP_LO) && (sample_i < UP_HI);
    ctrl_o[LAD_DOWN].active = (sample_i > DOWN_LO) && (sample_i < DOWN_HI);
    ctrl_o[LAD_CALL].active = (sample_i > CALL_LO) && (sample_i < CALL_HI);
    ctrl_o[LAD_PAIR].active = sample_i < PAIR_HI;
    for (int k = 0; k < NUM_LADDER; k++) begin
      ctrl_o[k].released = rel;
    end
  end

endmodule

[hw/rtl/kdsl_key.sv]
// ----------------------------------------------------------------------------
// kdsl_key
// One key machine: debounce counter, hold counter, long-press flag.
// ----------------------------------------------------------------------------
module kdsl_key import kdsl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  key_ctrl_t             ctrl_i,
  input  logic [COUNT_BITS-1:0] deb_lim_i,
  input  logic [COUNT_BITS-1:0] long_lim_i,
  output key_ev_e               ev_o
);

  logic                  held_q, held_d;
  logic                  lrep_q, lrep_d;
  logic [COUNT_BITS-1:0] deb_q, deb_d;
  logic [COUNT_BITS-1:0] hold_q, hold_d;
  logic [COUNT_BITS-1:0] deb_inc, hold_inc;
  logic                  long_hit;

  assign deb_inc  = deb_q + COUNT_BITS'(1);
  assign hold_inc = hold_q + COUNT_BITS'(1);
  assign long_hit = hold_inc > long_lim_i;

  always_comb begin
    held_d = held_q;
    lrep_d = lrep_q;
    deb_d  = deb_q;
    hold_d = hold_q;
    ev_o   = EV_NONE;
    if (held_q) begin
      hold_d = long_hit ? '0 : hold_inc;
      if (long_hit && !lrep_q) begin
        ev_o = EV_LONG;
      end
      lrep_d = lrep_q | long_hit;
      if (ctrl_i.released) begin
        held_d = 1'b0;
        hold_d = '0;
        if (lrep_q || long_hit) begin
          lrep_d = 1'b0;
        end else begin
          ev_o = EV_SHORT;
        end
      end
    end else if (ctrl_i.active) begin
      if (deb_inc > deb_lim_i) begin
        deb_d  = '0;
        held_d = 1'b1;
      end else begin
        deb_d = deb_inc;
      end
    end else begin
      deb_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      lrep_q <= 1'b0;
      deb_q  <= '0;
      hold_q <= '0;
    end else if (step_i) begin
      held_q <= held_d;
      lrep_q <= lrep_d;
      deb_q  <= deb_d;
      hold_q <= hold_d;
    end
  end

endmodule

[hw/rtl/key_debounce_short_long_press.sv]
// ----------------------------------------------------------------------------
// key_debounce_short_long_press
// Five-key debounce (standby pin plus four resistor-ladder keys) with
// per-key short and long press events.
// ----------------------------------------------------------------------------
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, in_data_i        | tick in
//   out     | out_valid_o, out_ready_i, out_data_o     | events out
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i          | write only
//
// One transaction per tick: a tick is captured in the input register, the
// five key machines update as it moves into the result register, and the
// result is offered from there. Throughput is one tick per cycle while the
// output is not stalled. Reset clears all key state and loads the default
// limits. A stalled output holds both stages; the input register still
// fills while the result waits.
// ----------------------------------------------------------------------------
module key_debounce_short_long_press import kdsl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  key_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output key_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [CFG_BITS-1:0]  cfg_data_i
);

  // Configuration registers
  logic [COUNT_BITS-1:0]  stby_long_q, stby_deb_q, lad_deb_q, lad_long_q;
  logic [SAMPLE_BITS-1:0] release_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stby_long_q <= RST_STBY_LONG;
      stby_deb_q  <= RST_STBY_DEB;
      lad_deb_q   <= RST_LADDER_DEB;
      lad_long_q  <= RST_LADDER_LONG;
      release_q   <= RST_RELEASE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STBY_LONG:   stby_long_q <= COUNT_BITS'(cfg_data_i);
        REG_STBY_DEB:    stby_deb_q  <= COUNT_BITS'(cfg_data_i);
        REG_LADDER_DEB:  lad_deb_q   <= COUNT_BITS'(cfg_data_i);
        REG_LADDER_LONG: lad_long_q  <= COUNT_BITS'(cfg_data_i);
        REG_RELEASE:     release_q   <= cfg_data_i[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the tick in the input register advances when the
  // result register is empty or being drained this cycle.
  logic    in_valid_q;
  key_in_t in_q;
  logic    advance;
  logic    out_valid_q;
  key_out_t out_q, out_d;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Key classification
  key_ctrl_t                 stby_ctrl;
  key_ctrl_t [NUM_LADDER-1:0] lad_ctrl;
  key_ev_e                   stby_ev;
  key_ev_e [NUM_LADDER-1:0]  lad_ev;

  assign stby_ctrl.active   = !in_q.stby_level;
  assign stby_ctrl.released = in_q.stby_level;

  kdsl_window u_window (
    .sample_i        (in_q.ladder_sample),
    .release_level_i (release_q),
    .ctrl_o          (lad_ctrl)
  );

  kdsl_key u_stby (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .ctrl_i     (stby_ctrl),
    .deb_lim_i  (stby_deb_q),
    .long_lim_i (stby_long_q),
    .ev_o       (stby_ev)
  );

  for (genvar k = 0; k < NUM_LADDER; k++) begin : g_ladder
    kdsl_key u_key (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (advance),
      .ctrl_i     (lad_ctrl[k]),
      .deb_lim_i  (lad_deb_q),
      .long_lim_i (lad_long_q),
      .ev_o       (lad_ev[k])
    );
  end

  always_comb begin
    out_d.stby_event = stby_ev;
    out_d.up_event   = lad_ev[LAD_UP];
    out_d.down_event = lad_ev[LAD_DOWN];
    out_d.call_event = lad_ev[LAD_CALL];
    out_d.pair_event = lad_ev[LAD_PAIR];
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
